>>> rtl/lspc_pkg.sv
package lspc_pkg;

  localparam int MAX_PIXELS_DEF = 256;
  localparam int TICK_W         = 15;
  localparam int COUNT_W        = 9;
  localparam int LEVEL_W        = 8;
  localparam int PIXEL_W        = 3 * LEVEL_W;
  localparam int INDEX_W        = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int SYMBOLS        = 24;
  localparam int BIT_CNT_W      = 5;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_FADE  = 2'd2;
  localparam logic [1:0] CMD_SEND  = 2'd3;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_FADE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 3'd4;

  localparam logic [TICK_W-1:0]  ZERO_HIGH_RST = 15'd24;
  localparam logic [TICK_W-1:0]  ZERO_LOW_RST  = 15'd64;
  localparam logic [TICK_W-1:0]  ONE_HIGH_RST  = 15'd64;
  localparam logic [TICK_W-1:0]  ONE_LOW_RST   = 15'd24;
  localparam logic [COUNT_W-1:0] COUNT_RST     = 9'd256;

  typedef struct packed {
    logic [1:0]         command;
    logic [INDEX_W-1:0] pixel_index;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              bit_value;
    logic              still_lit;
    logic              index_error;
    logic              last_result;
  } res_t;

  // One fade step: v - (1 + v/4), floored at zero.
  function automatic logic [LEVEL_W-1:0] dim_channel(input logic [LEVEL_W-1:0] v);
    logic [LEVEL_W-1:0] step;
    step = {2'b00, v[LEVEL_W-1:2]} + 8'd1;
    return (v > step) ? (v - step) : '0;
  endfunction

endpackage

>>> rtl/led_strip_pixel_controller.sv
// Pixel store and line symbol generator for a strip of addressable RGB LEDs.
// Commands arrive on cmd with cmd_valid and cmd_stall; results leave on res
// with res_valid and res_stall. The cfg channel writes the four symbol timing
// registers and the pixel count; cfg_ready is always high.
// Each command is worked on alone and cmd_stall stays high until its last
// result is in the output register. Steps, counted from acceptance:
//   write pixel: stored on acceptance if in range, then an acknowledge;
//   clear all: one pass over the store, then an acknowledge;
//   fade tick: pixels 1 to count-1 (count capped at MAX_PIXELS) each get a
//     read and a write state on the single read-modify-write store path;
//   send pixel: one store read, then 24 symbols, one per cycle unless stalled.
// The output register frees the command side as soon as the last result is
// loaded, so the next command is taken while that result still waits.
// A stalled receiver holds the result register and pauses symbol output.
// After reset the store is zeroed by a pass over all MAX_PIXELS addresses,
// during which no command is taken; configuration writes are taken throughout.
module led_strip_pixel_controller #(
  parameter int MAX_PIXELS = lspc_pkg::MAX_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  lspc_pkg::cmd_t                      cmd,
  output logic                                res_valid,
  input  logic                                res_stall,
  output lspc_pkg::res_t                      res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lspc_pkg::TICK_W-1:0]         cfg_data
);

  import lspc_pkg::*;

  localparam int AW   = $clog2(MAX_PIXELS);
  localparam int CW   = $clog2(MAX_PIXELS + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FREAD  = 3'd2;
  localparam logic [2:0] S_FWRITE = 3'd3;
  localparam logic [2:0] S_SLOAD  = 3'd4;
  localparam logic [2:0] S_SEND   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]           state;
  logic [TICK_W-1:0]    zero_high;
  logic [TICK_W-1:0]    zero_low;
  logic [TICK_W-1:0]    one_high;
  logic [TICK_W-1:0]    one_low;
  logic [COUNT_W-1:0]   pixel_count;
  logic [CW-1:0]        addr;
  logic [CMPW-1:0]      lim;
  logic                 lit;
  logic                 clear_ack;
  logic [1:0]           r_kind;
  logic                 r_err;
  logic [PIXEL_W-1:0]   pix;
  logic [BIT_CNT_W-1:0] bit_cnt;

  logic                 slot_free;
  logic                 res_load;
  logic                 cmd_fire;
  logic [CMPW-1:0]      cnt_wide;
  logic [CMPW-1:0]      live;
  logic                 idx_err;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [PIXEL_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [PIXEL_W-1:0]   ram_rdata;
  logic [PIXEL_W-1:0]   dimmed;

  lspc_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign slot_free = !res_valid || !res_stall;
  assign res_load  = slot_free && ((state == S_SEND) || (state == S_RESULT));

  always_comb begin
    cnt_wide = CMPW'(pixel_count);
    live     = (cnt_wide > CMPW'(MAX_PIXELS)) ? CMPW'(MAX_PIXELS) : cnt_wide;
    idx_err  = (CMPW'(cmd.pixel_index) >= live);
    dimmed   = {dim_channel(ram_rdata[23:16]), dim_channel(ram_rdata[15:8]),
                dim_channel(ram_rdata[7:0])};
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(addr);
    ram_wdata = '0;
    ram_raddr = AW'(addr);
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = AW'(cmd.pixel_index);
        if (cmd_fire && (cmd.command == CMD_WRITE) && !idx_err) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cmd.pixel_index);
          ram_wdata = {cmd.green_level, cmd.red_level, cmd.blue_level};
        end
      end
      S_FWRITE: begin
        ram_we    = 1'b1;
        ram_wdata = dimmed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      addr        <= '0;
      clear_ack   <= 1'b0;
      lit         <= 1'b0;
      res_valid   <= 1'b0;
      zero_high   <= ZERO_HIGH_RST;
      zero_low    <= ZERO_LOW_RST;
      one_high    <= ONE_HIGH_RST;
      one_low     <= ONE_LOW_RST;
      pixel_count <= COUNT_RST;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ZERO_HIGH: zero_high   <= cfg_data;
          CFG_ZERO_LOW:  zero_low    <= cfg_data;
          CFG_ONE_HIGH:  one_high    <= cfg_data;
          CFG_ONE_LOW:   one_low     <= cfg_data;
          CFG_COUNT:     pixel_count <= cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          if (addr == CW'(MAX_PIXELS - 1)) begin
            addr  <= '0;
            state <= clear_ack ? S_RESULT : S_IDLE;
          end else begin
            addr <= addr + CW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_fire) begin
            unique case (cmd.command)
              CMD_CLEAR: begin
                r_err     <= 1'b0;
                r_kind    <= KIND_ACK;
                clear_ack <= 1'b1;
                addr      <= '0;
                state     <= S_CLEAR;
              end
              CMD_FADE: begin
                r_err  <= 1'b0;
                r_kind <= KIND_FADE;
                lit    <= 1'b0;
                addr   <= CW'(1);
                lim    <= live;
                state  <= (live > CMPW'(1)) ? S_FREAD : S_RESULT;
              end
              CMD_WRITE: begin
                r_kind <= KIND_ACK;
                r_err  <= idx_err;
                state  <= S_RESULT;
              end
              CMD_SEND: begin
                r_kind <= KIND_ACK;
                r_err  <= idx_err;
                state  <= idx_err ? S_RESULT : S_SLOAD;
              end
              default: begin
              end
            endcase
          end
        end
        S_FREAD: begin
          state <= S_FWRITE;
        end
        S_FWRITE: begin
          if (dimmed != '0) begin
            lit <= 1'b1;
          end
          if ((CMPW'(addr) + CMPW'(1)) == lim) begin
            state <= S_RESULT;
          end else begin
            addr  <= addr + CW'(1);
            state <= S_FREAD;
          end
        end
        S_SLOAD: begin
          pix     <= ram_rdata;
          bit_cnt <= '0;
          state   <= S_SEND;
        end
        S_SEND: begin
          if (slot_free) begin
            res.result_kind <= KIND_SYMBOL;
            res.high_ticks  <= pix[PIXEL_W-1] ? one_high : zero_high;
            res.low_ticks   <= pix[PIXEL_W-1] ? one_low : zero_low;
            res.bit_value   <= pix[PIXEL_W-1];
            res.still_lit   <= 1'b0;
            res.index_error <= 1'b0;
            res.last_result <= (bit_cnt == BIT_CNT_W'(SYMBOLS - 1));
            pix             <= {pix[PIXEL_W-2:0], 1'b0};
            bit_cnt         <= bit_cnt + BIT_CNT_W'(1);
            if (bit_cnt == BIT_CNT_W'(SYMBOLS - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            res.result_kind <= r_kind;
            res.high_ticks  <= '0;
            res.low_ticks   <= '0;
            res.bit_value   <= 1'b0;
            res.still_lit   <= lit && (r_kind == KIND_FADE);
            res.index_error <= r_err;
            res.last_result <= 1'b1;
            clear_ack       <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fade_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWRITE) |-> ((addr != '0) && (CMPW'(addr) < lim)))
    else $error("fade address outside the pixels in use");

  a_symbol_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (bit_cnt < BIT_CNT_W'(SYMBOLS)))
    else $error("symbol counter ran past the last symbol");

  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.result_kind != KIND_SYMBOL)) |->
      ((res.high_ticks == '0) && (res.low_ticks == '0) && !res.bit_value &&
       res.last_result))
    else $error("non-symbol result carries symbol fields");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |=> (cmd_stall || (res_valid && res.last_result)))
    else $error("command taken before the last symbol was loaded");
`endif

endmodule

>>> rtl/lspc_ram.sv
module lspc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
